### src/met_pkg.sv
package met_pkg;

    localparam int DATA_W  = 32;
    localparam int STEP_W  = 31;
    localparam int COUNT_W = 8;
    localparam int INDEX_W = 2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;

    localparam logic signed [DATA_W-1:0] ORIGIN_RE_RESET = -32'sd536870912;
    localparam logic signed [DATA_W-1:0] ORIGIN_IM_RESET = -32'sd536870912;
    localparam logic [STEP_W-1:0]        STEP_RESET      = 31'd994205;
    localparam logic [COUNT_W-1:0]       MAX_ITER_RESET  = 8'd255;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef enum logic [INDEX_W-1:0] {
        REG_ORIGIN_RE = 2'd0,
        REG_ORIGIN_IM = 2'd1,
        REG_STEP      = 2'd2,
        REG_MAX_ITER  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_re;
        logic signed [DATA_W-1:0] origin_im;
        logic [STEP_W-1:0]        step;
        logic [COUNT_W-1:0]       max_iter;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] cr;
        logic signed [DATA_W-1:0] ci;
    } point_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_OUT
    } core_state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/met_fifo.sv
module met_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0]                mem [met_pkg::FIFO_DEPTH];
    logic [met_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [met_pkg::FIFO_PTR_W-1:0]  wr_ptr_next;
    logic [met_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [met_pkg::FIFO_PTR_W-1:0]  rd_ptr_next;
    logic [met_pkg::FIFO_PTR_W:0]    count_reg;
    logic [met_pkg::FIFO_PTR_W:0]    count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (count_reg == (met_pkg::FIFO_PTR_W+1)'(met_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // The occupancy tracks the pointers: equal pointers mean either empty or full.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("fifo pointers disagree with occupancy");

endmodule

### src/met_front.sv
module met_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  met_pkg::cfg_t         cfg,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    output logic                  pt_push,
    output met_pkg::point_t       pt_data,
    input  logic                  pt_full
);

    localparam int PROD_W = COORD_BITS + met_pkg::STEP_W;
    localparam int SUM_W  = PROD_W + 2;

    logic                    valid_reg;
    logic                    valid_next;
    logic [PROD_W-1:0]       prod_x_reg;
    logic [PROD_W-1:0]       prod_y_reg;
    logic                    accept;
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;

    assign full    = valid_reg && pt_full;
    assign accept  = push && !full;
    assign pt_push = valid_reg && !pt_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end else if (pt_push)
        begin
            valid_next = 1'b0;
        end
    end

    // Offset products are nonnegative, so a zero bit on top keeps them nonnegative as signed values.
    assign sum_re = $signed({1'b0, prod_x_reg}) + SUM_W'(cfg.origin_re);
    assign sum_im = $signed({1'b0, prod_y_reg}) + SUM_W'(cfg.origin_im);

    assign pt_data.cr = met_pkg::sat32(64'(sum_re));
    assign pt_data.ci = met_pkg::sat32(64'(sum_im));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_x_reg <= PROD_W'(pixel_x) * PROD_W'(cfg.step);
            prod_y_reg <= PROD_W'(pixel_y) * PROD_W'(cfg.step);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && pt_full) |=> valid_reg)
        else $error("front stage dropped a pending point");

endmodule

### src/met_core.sv
module met_core #(
    parameter int FRAC_BITS = 28
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  met_pkg::cfg_t                cfg,
    input  met_pkg::point_t              pt_data,
    input  logic                         pt_empty,
    output logic                         pt_pop,
    output logic [met_pkg::COUNT_W-1:0]  res_data,
    output logic                         res_push,
    input  logic                         res_full
);

    localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
    localparam logic [64:0] ESC_LIMIT =
        (ESC_SHIFT < 64) ? (65'd1 << ESC_SHIFT) : {65{1'b1}};

    met_pkg::core_state_t                state_reg;
    met_pkg::core_state_t                state_next;

    logic signed [met_pkg::DATA_W-1:0]   cr_reg;
    logic signed [met_pkg::DATA_W-1:0]   ci_reg;
    logic signed [met_pkg::DATA_W-1:0]   zr_reg;
    logic signed [met_pkg::DATA_W-1:0]   zi_reg;
    logic signed [63:0]                  rr_reg;
    logic signed [63:0]                  ii_reg;
    logic signed [63:0]                  ri_reg;
    logic signed [63:0]                  rr_next;
    logic signed [63:0]                  ii_next;
    logic signed [63:0]                  ri_next;
    logic [met_pkg::COUNT_W-1:0]         count_reg;
    logic [met_pkg::COUNT_W-1:0]         count_inc;
    logic                                first_reg;

    logic signed [63:0]                  re_sum;
    logic signed [63:0]                  im_sum;
    logic signed [met_pkg::DATA_W-1:0]   zr_new;
    logic signed [met_pkg::DATA_W-1:0]   zi_new;
    logic [63:0]                         mag;
    logic                                escape;
    logic                                last;

    assign rr_next = zr_reg * zr_reg;
    assign ii_next = zi_reg * zi_reg;
    assign ri_next = zr_reg * zi_reg;

    // The squares held after a multiply serve twice: as the magnitude of the
    // point just reached and as the terms of the next update.
    assign re_sum = ((rr_reg - ii_reg) >>> FRAC_BITS) + 64'(cr_reg);
    assign im_sum = (ri_reg >>> (FRAC_BITS - 1)) + 64'(ci_reg);
    assign zr_new = met_pkg::sat32(re_sum);
    assign zi_new = met_pkg::sat32(im_sum);

    assign mag       = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign escape    = ({1'b0, mag} > ESC_LIMIT);
    assign count_inc = count_reg + 1'b1;
    assign last      = (count_inc == cfg.max_iter);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            met_pkg::ST_IDLE:
            begin
                if (!pt_empty)
                begin
                    state_next = (cfg.max_iter == '0) ? met_pkg::ST_OUT : met_pkg::ST_MUL;
                end
            end
            met_pkg::ST_MUL:
            begin
                state_next = met_pkg::ST_UPD;
            end
            met_pkg::ST_UPD:
            begin
                if (!first_reg && (escape || last))
                begin
                    state_next = met_pkg::ST_OUT;
                end else
                begin
                    state_next = met_pkg::ST_MUL;
                end
            end
            met_pkg::ST_OUT:
            begin
                if (!res_full)
                begin
                    state_next = met_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = met_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pt_pop   = 1'b0;
        res_push = 1'b0;
        unique case (state_reg)
            met_pkg::ST_IDLE: pt_pop   = !pt_empty;
            met_pkg::ST_OUT:  res_push = !res_full;
            default:
            begin
                pt_pop   = 1'b0;
                res_push = 1'b0;
            end
        endcase
    end

    assign res_data = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= met_pkg::ST_IDLE;
        end else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_pop)
        begin
            cr_reg    <= pt_data.cr;
            ci_reg    <= pt_data.ci;
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
            first_reg <= 1'b1;
        end
        if (state_reg == met_pkg::ST_MUL)
        begin
            rr_reg <= rr_next;
            ii_reg <= ii_next;
            ri_reg <= ri_next;
        end
        if (state_reg == met_pkg::ST_UPD)
        begin
            first_reg <= 1'b0;
            zr_reg    <= zr_new;
            zi_reg    <= zi_new;
            if (!first_reg && !escape)
            begin
                count_reg <= count_inc;
            end
        end
    end

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == met_pkg::ST_OUT) |-> (count_reg <= cfg.max_iter))
        else $error("escape count exceeds the iteration limit");

    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (state_reg == met_pkg::ST_IDLE))
        else $error("core did not return to idle after a result");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != met_pkg::ST_IDLE) |-> !pt_pop)
        else $error("core took a point while busy");

endmodule

### src/mandelbrot_escape_time_top.sv
// Channel | Direction | Handshake        | Payload
// --------+-----------+------------------+------------------------------
// pixel   | in        | push / full      | pixel_x, pixel_y
// result  | out       | pop / empty      | escape_count
// config  | in        | wr_en            | wr_index, wr_data
//
// A pixel passes the front stage and then the core, which runs updates until
// escape or max_iter; a zero max_iter skips the updates and gives a zero count.
// Each update has two steps: the three 32x32 multipliers, then add and test.
// The result is registered in the result queue before it reaches the output ports.
// Reset loads the register defaults; there is no clearing pass.
// The front accepts a new pixel while the core iterates; both sides stall
// independently through two-entry queues.
module mandelbrot_escape_time_top #(
    parameter int FRAC_BITS  = 28,
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [COORD_BITS-1:0]         pixel_x,
    input  logic [COORD_BITS-1:0]         pixel_y,
    output logic                          empty,
    input  logic                          pop,
    output logic [met_pkg::COUNT_W-1:0]   escape_count,
    input  logic                          wr_en,
    input  logic [met_pkg::INDEX_W-1:0]   wr_index,
    input  logic [met_pkg::DATA_W-1:0]    wr_data
);

    met_pkg::cfg_t                 cfg_reg;
    met_pkg::cfg_t                 cfg_next;
    met_pkg::point_t               front_pt;
    met_pkg::point_t               core_pt;
    logic                          front_push;
    logic                          pt_full;
    logic                          pt_empty;
    logic                          pt_pop;
    logic [met_pkg::COUNT_W-1:0]   res_data;
    logic                          res_push;
    logic                          res_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                met_pkg::REG_ORIGIN_RE: cfg_next.origin_re = $signed(wr_data);
                met_pkg::REG_ORIGIN_IM: cfg_next.origin_im = $signed(wr_data);
                met_pkg::REG_STEP:      cfg_next.step      = wr_data[met_pkg::STEP_W-1:0];
                met_pkg::REG_MAX_ITER:  cfg_next.max_iter  = wr_data[met_pkg::COUNT_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_re <= met_pkg::ORIGIN_RE_RESET;
            cfg_reg.origin_im <= met_pkg::ORIGIN_IM_RESET;
            cfg_reg.step      <= met_pkg::STEP_RESET;
            cfg_reg.max_iter  <= met_pkg::MAX_ITER_RESET;
        end else
        begin
            cfg_reg <= cfg_next;
        end
    end

    met_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .full    (full),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .pt_push (front_push),
        .pt_data (front_pt),
        .pt_full (pt_full)
    );

    met_fifo #(
        .WIDTH($bits(met_pkg::point_t))
    ) u_pt_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_pt),
        .full  (pt_full),
        .pop   (pt_pop),
        .rdata (core_pt),
        .empty (pt_empty)
    );

    met_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pt_data  (core_pt),
        .pt_empty (pt_empty),
        .pt_pop   (pt_pop),
        .res_data (res_data),
        .res_push (res_push),
        .res_full (res_full)
    );

    met_fifo #(
        .WIDTH(met_pkg::COUNT_W)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (escape_count),
        .empty (empty)
    );

endmodule

### tb/tb_mandelbrot_escape_time_top.sv
module tb_mandelbrot_escape_time_top;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
    } pixel_t;

    // Holds the register copy, predicts the iteration count of every accepted
    // pixel and matches the counts that come out in order.
    class escape_count_board;
        localparam int FRAC = 28;
        localparam longint unsigned ESCAPE_LIMIT = 64'd4 << (2 * FRAC);

        met_pkg::cfg_t cfg;
        logic [7:0]    pending_counts[$];
        int            mismatches;
        int            checked;
        int            limit_hits;

        function new();
            cfg.origin_re = met_pkg::ORIGIN_RE_RESET;
            cfg.origin_im = met_pkg::ORIGIN_IM_RESET;
            cfg.step      = met_pkg::STEP_RESET;
            cfg.max_iter  = met_pkg::MAX_ITER_RESET;
            mismatches    = 0;
            checked       = 0;
            limit_hits    = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function logic [7:0] iterate_pixel(logic [11:0] px, logic [11:0] py);
            longint cr;
            longint ci;
            longint zr;
            longint zi;
            longint nr;
            longint ni;
            longint unsigned mag;
            int n;
            cr = clamp32(longint'($signed(cfg.origin_re)) + longint'(px) * longint'(cfg.step));
            ci = clamp32(longint'($signed(cfg.origin_im)) + longint'(py) * longint'(cfg.step));
            zr = 0;
            zi = 0;
            n = 0;
            while (n < int'(cfg.max_iter)) begin
                nr = clamp32(((zr * zr - zi * zi) >>> FRAC) + cr);
                ni = clamp32(((zr * zi) >>> (FRAC - 1)) + ci);
                zr = nr;
                zi = ni;
                mag = $unsigned(zr * zr) + $unsigned(zi * zi);
                if (mag > ESCAPE_LIMIT)
                    break;
                n++;
            end
            return n[7:0];
        endfunction

        function void note_pixel(logic [11:0] px, logic [11:0] py);
            logic [7:0] expected;
            expected = iterate_pixel(px, py);
            if (expected == cfg.max_iter)
                limit_hits++;
            pending_counts.insert(pending_counts.size(), expected);
        endfunction

        function void check_count(logic [7:0] got);
            logic [7:0] expected;
            checked++;
            if (pending_counts.size() == 0) begin
                $display("%0t: escape_count expected none, got %0d", $time, got);
                mismatches++;
            end else begin
                expected = pending_counts.pop_front();
                if (got !== expected) begin
                    $display("%0t: escape_count expected %0d, got %0d", $time, expected, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        push;
    logic                        full;
    logic [11:0]                 pixel_x;
    logic [11:0]                 pixel_y;
    logic                        empty;
    logic                        pop;
    logic [met_pkg::COUNT_W-1:0] escape_count;
    logic                        wr_en;
    logic [met_pkg::INDEX_W-1:0] wr_index;
    logic [met_pkg::DATA_W-1:0]  wr_data;

    escape_count_board board;
    pixel_t            pixel_batch[$];
    int                settings_used;

    mandelbrot_escape_time_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .empty        (empty),
        .pop          (pop),
        .escape_count (escape_count),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic write_reg(input met_pkg::reg_index_t idx, input logic [31:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // The block only sees the low bits of step and max_iter, so the copy is
    // masked the same way while the raw word goes to the port.
    task automatic apply_setting(input logic [31:0] re, input logic [31:0] im,
                                 input logic [31:0] st, input logic [31:0] iter);
        write_reg(met_pkg::REG_ORIGIN_RE, re);
        write_reg(met_pkg::REG_ORIGIN_IM, im);
        write_reg(met_pkg::REG_STEP, st);
        write_reg(met_pkg::REG_MAX_ITER, iter);
        board.cfg.origin_re = re;
        board.cfg.origin_im = im;
        board.cfg.step      = st[met_pkg::STEP_W-1:0];
        board.cfg.max_iter  = iter[met_pkg::COUNT_W-1:0];
        settings_used++;
    endtask

    task automatic feed_pixels(input bit no_gaps);
        int gap;
        foreach (pixel_batch[i]) begin
            gap = no_gaps ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push    <= 1'b1;
            pixel_x <= pixel_batch[i].x;
            pixel_y <= pixel_batch[i].y;
            do @(posedge clk); while (full);
            board.note_pixel(pixel_batch[i].x, pixel_batch[i].y);
        end
        push <= 1'b0;
    endtask

    task automatic drain_counts(input int n, input bit no_stalls);
        int gap;
        repeat (n) begin
            gap = no_stalls ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            board.check_count(escape_count);
        end
    endtask

    // Pop is not driven here; after a batch it stays high, so any result that shows up uninvited is caught.
    task automatic settle(input int cycles);
        repeat (cycles) begin
            @(posedge clk);
            if (pop && !empty)
                board.check_count(escape_count);
        end
    endtask

    task automatic run_batch();
        bit quiet_send;
        bit quiet_take;
        int n;
        quiet_send = ($urandom_range(0, 3) == 0);
        quiet_take = ($urandom_range(0, 3) == 0);
        n = pixel_batch.size();
        fork
            feed_pixels(quiet_send);
            drain_counts(n, quiet_take);
        join
        settle(4);
    endtask

    task automatic add_pixel(input logic [11:0] x, input logic [11:0] y);
        pixel_t p;
        p.x = x;
        p.y = y;
        pixel_batch.insert(pixel_batch.size(), p);
    endtask

    initial
    begin
        #100_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int fed;
        int mode;
        int n;
        int wide_share;
        int window;
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] st;
        logic [31:0] iter;

        board         = new();
        settings_used = 1;
        fed           = 0;
        rst_n    = 1'b0;
        push     = 1'b0;
        pop      = 1'b0;
        pixel_x  = '0;
        pixel_y  = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        settle(2);

        // Reset view: corners, the origin of the plane, the period-two bulb
        // and alternating bit patterns.
        pixel_batch.delete();
        add_pixel(12'd0, 12'd0);
        add_pixel(12'd4095, 12'd4095);
        add_pixel(12'd540, 12'd540);
        add_pixel(12'd270, 12'd540);
        add_pixel(12'hAAA, 12'h555);
        add_pixel(12'h555, 12'hAAA);
        add_pixel(12'd4095, 12'd0);
        run_batch();

        // A zero iteration limit gives a zero count.
        apply_setting(32'h0, 32'h0, 32'h0, 32'hFFFF_FF00);
        pixel_batch.delete();
        add_pixel(12'd0, 12'd0);
        add_pixel(12'd4095, 12'd4095);
        run_batch();

        // Extreme origins and the largest step: the coordinate sums saturate.
        apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd255);
        pixel_batch.delete();
        add_pixel(12'd4095, 12'd4095);
        add_pixel(12'd0, 12'd0);
        add_pixel(12'd1, 12'd0);
        run_batch();

        // c = -2 sits exactly on the escape boundary and never leaves it.
        apply_setting(32'hE000_0000, 32'h0, 32'h0, 32'd255);
        pixel_batch.delete();
        add_pixel(12'd7, 12'd9);
        run_batch();

        // Most negative real part with a single iteration allowed.
        apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1);
        pixel_batch.delete();
        add_pixel(12'd4095, 12'd4095);
        add_pixel(12'd0, 12'd0);
        run_batch();

        // Just past the cusp at 0.25 the orbit escapes slowly.
        apply_setting(32'h0410_0000, 32'h0, 32'h0010_0000, 32'd200);
        pixel_batch.delete();
        add_pixel(12'd0, 12'd0);
        add_pixel(12'd3, 12'd0);
        add_pixel(12'd0, 12'd3);
        run_batch();

        while (fed < 1750) begin
            mode = $urandom_range(0, 9);
            n = $urandom_range(60, 140);
            wide_share = 15;
            window = 63;
            if (mode <= 5) begin
                // A small window somewhere around the set.
                re = -32'sd671088640 + $urandom_range(0, 536870912);
                im = -32'sd402653184 + $urandom_range(0, 268435456);
                st = $urandom_range(1 << 14, 1 << 22);
                case ($urandom_range(0, 5))
                    0: iter = 32'd255;
                    1: iter = 32'd1;
                    default: iter = $urandom_range(1, 48);
                endcase
            end else if (mode <= 7) begin
                re = -32'sd536870912;
                im = -32'sd536870912;
                st = 32'd994205;
                iter = $urandom_range(1, 64);
                window = 1079;
                wide_share = 30;
            end else begin
                re = $urandom;
                im = $urandom;
                st = $urandom;
                iter = $urandom;
                wide_share = 100;
            end
            apply_setting(re, im, st, iter);
            pixel_batch.delete();
            repeat (n) begin
                if ($urandom_range(1, 100) <= wide_share)
                    add_pixel(12'($urandom), 12'($urandom));
                else
                    add_pixel(12'($urandom_range(0, window)),
                              12'($urandom_range(0, window)));
            end
            run_batch();
            fed += n;
        end

        settle(600);
        if (board.pending_counts.size() != 0) begin
            $display("%0t: %0d escape counts still expected at the end",
                     $time, board.pending_counts.size());
            board.mismatches++;
        end
        $display("Checked %0d escape counts over %0d register settings;",
                 board.checked, settings_used);
        $display("%0d pixels ran all the way to the iteration limit.", board.limit_hits);
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
src/met_pkg.sv
src/met_fifo.sv
src/met_front.sv
src/met_core.sv
src/mandelbrot_escape_time_top.sv
tb/tb_mandelbrot_escape_time_top.sv
